### rtl/core/vt44_pkg.sv
// Shared types and constants for the 4x4 vertex transform chain.
package vt44_pkg;

  localparam int IO_BITS       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int DIM           = 4;
  localparam int IDX_BITS      = 2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  // control fields that ride along with every transaction in the chain
  typedef struct packed {
    logic                xform;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } ctrl_t;

endpackage

### rtl/core/vt44_cell.sv
// One row cell: holds matrix row ROW_IDX, multiplies it by v[ROW_IDX], adds into partial sums.
module vt44_cell #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int ROW_IDX   = 0
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  vt44_pkg::ctrl_t                            up_ctrl,
  input  logic signed [WORD_BITS-1:0]                up_elem,
  input  logic signed [WORD_BITS-1:0]                up_vec [vt44_pkg::DIM],
  input  logic signed [2*WORD_BITS-FRAC_BITS+1:0]    up_acc [vt44_pkg::DIM],
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output vt44_pkg::ctrl_t                            dn_ctrl,
  output logic signed [WORD_BITS-1:0]                dn_elem,
  output logic signed [WORD_BITS-1:0]                dn_vec [vt44_pkg::DIM],
  output logic signed [2*WORD_BITS-FRAC_BITS+1:0]    dn_acc [vt44_pkg::DIM]
);
  import vt44_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int AW = 2 * WORD_BITS - FRAC_BITS + 2;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] ONE_RAW = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
  // 1.0 saturates to the largest word when it does not fit
  localparam logic signed [W-1:0] ONE = (FRAC_BITS < W - 1) ? ONE_RAW : WMAX;

  logic signed [W-1:0]  row_reg [DIM];

  logic                 m_valid;
  logic                 m_ready;
  ctrl_t                m_ctrl;
  logic signed [W-1:0]  m_elem;
  logic signed [W-1:0]  m_vec  [DIM];
  logic signed [AW-1:0] m_acc  [DIM];
  logic signed [PW-1:0] m_prod [DIM];

  logic                 a_ready;

  assign m_ready  = !m_valid || a_ready;
  assign a_ready  = !dn_valid || dn_ready;
  assign up_ready = m_ready;

  // multiply stage; element writes land here so they stay in transaction order
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      for (int c = 0; c < DIM; c++) begin
        row_reg[c] <= (c == ROW_IDX) ? ONE : '0;
      end
    end else begin
      if (m_ready) begin
        m_valid <= up_valid;
      end
      if (up_valid && m_ready && up_ctrl.xform == ACT_LOAD &&
          up_ctrl.row == IDX_BITS'(ROW_IDX)) begin
        row_reg[up_ctrl.col] <= up_elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && m_ready) begin
      m_ctrl <= up_ctrl;
      m_elem <= up_elem;
      for (int c = 0; c < DIM; c++) begin
        m_vec[c]  <= up_vec[c];
        m_acc[c]  <= up_acc[c];
        m_prod[c] <= PW'(row_reg[c]) * PW'(up_vec[ROW_IDX]);
      end
    end
  end

  // accumulate stage: floor shift of the product, then add
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (a_ready) begin
      dn_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && a_ready) begin
      dn_ctrl <= m_ctrl;
      dn_elem <= m_elem;
      for (int c = 0; c < DIM; c++) begin
        dn_vec[c] <= m_vec[c];
        dn_acc[c] <= m_acc[c] + AW'(m_prod[c] >>> FRAC_BITS);
      end
    end
  end

endmodule

### rtl/core/vt44_sat.sv
// Output stage: saturates the four sums to a word and holds the result transaction.
module vt44_sat #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  input  vt44_pkg::ctrl_t                          up_ctrl,
  input  logic signed [2*WORD_BITS-FRAC_BITS+1:0]  up_acc [vt44_pkg::DIM],
  output logic                                     dn_valid,
  input  logic                                     dn_ready,
  output logic signed [vt44_pkg::IO_BITS-1:0]      dn_out [vt44_pkg::DIM],
  output logic                                     dn_ovf
);
  import vt44_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * WORD_BITS - FRAC_BITS + 2;

  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] AMAX = AW'(WMAX);
  localparam logic signed [AW-1:0] AMIN = AW'(WMIN);

  logic signed [W-1:0] sat [DIM];
  logic [DIM-1:0]      clip;
  logic                take;

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      if (up_acc[c] > AMAX) begin
        sat[c]  = WMAX;
        clip[c] = 1'b1;
      end else if (up_acc[c] < AMIN) begin
        sat[c]  = WMIN;
        clip[c] = 1'b1;
      end else begin
        sat[c]  = up_acc[c][W-1:0];
        clip[c] = 1'b0;
      end
    end
  end

  // load transactions end here without a result
  assign up_ready = (up_ctrl.xform == ACT_LOAD) || !dn_valid || dn_ready;
  assign take     = up_valid && (up_ctrl.xform == ACT_XFORM) && (!dn_valid || dn_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (take) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int c = 0; c < DIM; c++) begin
        dn_out[c] <= IO_BITS'(sat[c]);
      end
      dn_ovf <= |clip;
    end
  end

endmodule

### rtl/core/vertex_transform_4x4_unit.sv
// A transform transaction reaches the output through nine registers: multiply and accumulate
// in each of four row cells, then the saturating output register.
// Throughput: one transaction per cycle unless stalled; 4 multipliers per row cell, 16 in all.
// Element loads travel the same chain and update a row as they pass its cell; no result.
// Reset: matrix returns to identity, all pipeline stages and the output go empty.
module vertex_transform_4x4_unit #(
  parameter int WORD_BITS = vt44_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vt44_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [vt44_pkg::IDX_BITS-1:0]        elem_row,
  input  logic [vt44_pkg::IDX_BITS-1:0]        elem_col,
  input  logic signed [vt44_pkg::IO_BITS-1:0]  elem_value,
  input  logic signed [vt44_pkg::IO_BITS-1:0]  vec_x,
  input  logic signed [vt44_pkg::IO_BITS-1:0]  vec_y,
  input  logic signed [vt44_pkg::IO_BITS-1:0]  vec_z,
  input  logic signed [vt44_pkg::IO_BITS-1:0]  vec_w,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vt44_pkg::IO_BITS-1:0]  out_x,
  output logic signed [vt44_pkg::IO_BITS-1:0]  out_y,
  output logic signed [vt44_pkg::IO_BITS-1:0]  out_z,
  output logic signed [vt44_pkg::IO_BITS-1:0]  out_w,
  output logic                                 overflow
);
  import vt44_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * WORD_BITS - FRAC_BITS + 2;

  logic                 lk_valid [DIM+1];
  logic                 lk_ready [DIM+1];
  ctrl_t                lk_ctrl  [DIM+1];
  logic signed [AW-1:0] lk_acc   [DIM+1][DIM];
  logic signed [W-1:0]  lk_elem  [DIM];
  logic signed [W-1:0]  lk_vec   [DIM][DIM];

  logic signed [IO_BITS-1:0] res [DIM];

  assign lk_valid[0]      = in_valid;
  assign in_ready         = lk_ready[0];
  assign lk_ctrl[0].xform = action;
  assign lk_ctrl[0].row   = elem_row;
  assign lk_ctrl[0].col   = elem_col;
  assign lk_elem[0]       = elem_value[W-1:0];
  assign lk_vec[0][0]     = vec_x[W-1:0];
  assign lk_vec[0][1]     = vec_y[W-1:0];
  assign lk_vec[0][2]     = vec_z[W-1:0];
  assign lk_vec[0][3]     = vec_w[W-1:0];

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      lk_acc[0][c] = '0;
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_cell
    if (i < DIM - 1) begin : g_mid
      vt44_cell #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ROW_IDX   (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (lk_valid[i]),
        .up_ready (lk_ready[i]),
        .up_ctrl  (lk_ctrl[i]),
        .up_elem  (lk_elem[i]),
        .up_vec   (lk_vec[i]),
        .up_acc   (lk_acc[i]),
        .dn_valid (lk_valid[i+1]),
        .dn_ready (lk_ready[i+1]),
        .dn_ctrl  (lk_ctrl[i+1]),
        .dn_elem  (lk_elem[i+1]),
        .dn_vec   (lk_vec[i+1]),
        .dn_acc   (lk_acc[i+1])
      );
    end else begin : g_last
      // last cell: vector and element are not needed past here
      vt44_cell #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ROW_IDX   (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (lk_valid[i]),
        .up_ready (lk_ready[i]),
        .up_ctrl  (lk_ctrl[i]),
        .up_elem  (lk_elem[i]),
        .up_vec   (lk_vec[i]),
        .up_acc   (lk_acc[i]),
        .dn_valid (lk_valid[i+1]),
        .dn_ready (lk_ready[i+1]),
        .dn_ctrl  (lk_ctrl[i+1]),
        .dn_elem  (),
        .dn_vec   (),
        .dn_acc   (lk_acc[i+1])
      );
    end
  end

  vt44_sat #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lk_valid[DIM]),
    .up_ready (lk_ready[DIM]),
    .up_ctrl  (lk_ctrl[DIM]),
    .up_acc   (lk_acc[DIM]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_out   (res),
    .dn_ovf   (overflow)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

`ifndef SYNTHESIS
  localparam logic signed [IO_BITS-1:0] SMAX = IO_BITS'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [IO_BITS-1:0] SMIN = -SMAX - IO_BITS'(1);

  // a flagged result has at least one component pinned at a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      (out_x == SMAX || out_x == SMIN || out_y == SMAX || out_y == SMIN ||
       out_z == SMAX || out_z == SMIN || out_w == SMAX || out_w == SMIN))
    else $error("overflow set with no saturated component");

  // outputs are sign extensions of a word
  a_sext: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x <= SMAX && out_x >= SMIN && out_y <= SMAX && out_y >= SMIN &&
                   out_z <= SMAX && out_z >= SMIN && out_w <= SMAX && out_w >= SMIN))
    else $error("output outside word range");

  // no result appears at the output right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("result appeared right after reset");
`endif

endmodule

### tb/vertex_transform_4x4_unit_tb.sv
// Self-checking testbench for the 4x4 fixed-point vertex transform unit.
module vertex_transform_4x4_unit_tb;
  import vt44_pkg::*;

  localparam int     FRAC      = FRAC_BITS_DEF;
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam int     QUIET_LO  = 180;
  localparam int     QUIET_HI  = 320;
  localparam int     IDLE_PCT  = 18;
  localparam int     DRAIN_CYC = 20;

  localparam logic signed [IO_BITS-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [IO_BITS-1:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [IO_BITS-1:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [IO_BITS-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [IO_BITS-1:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [IO_BITS-1:0] Q_LSB_NEG = 32'shFFFF_FFFF;

  typedef struct packed {
    logic                       act;
    logic [IDX_BITS-1:0]        row;
    logic [IDX_BITS-1:0]        col;
    logic signed [IO_BITS-1:0]  value;
    logic signed [IO_BITS-1:0]  x;
    logic signed [IO_BITS-1:0]  y;
    logic signed [IO_BITS-1:0]  z;
    logic signed [IO_BITS-1:0]  w;
  } vt_item_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0]  x;
    logic signed [IO_BITS-1:0]  y;
    logic signed [IO_BITS-1:0]  z;
    logic signed [IO_BITS-1:0]  w;
    logic                       ovf;
  } vertex_out_t;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       action     = ACT_LOAD;
  logic [IDX_BITS-1:0]        elem_row   = '0;
  logic [IDX_BITS-1:0]        elem_col   = '0;
  logic signed [IO_BITS-1:0]  elem_value = '0;
  logic signed [IO_BITS-1:0]  vec_x      = '0;
  logic signed [IO_BITS-1:0]  vec_y      = '0;
  logic signed [IO_BITS-1:0]  vec_z      = '0;
  logic signed [IO_BITS-1:0]  vec_w      = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [IO_BITS-1:0]  out_x;
  logic signed [IO_BITS-1:0]  out_y;
  logic signed [IO_BITS-1:0]  out_z;
  logic signed [IO_BITS-1:0]  out_w;
  logic                       overflow;

  logic signed [IO_BITS-1:0]  matrix_q [DIM*DIM];
  vt_item_t                   stim_q [$];
  vertex_out_t                vertex_q [$];
  vt_item_t                   cur_item;

  int n_accepted = 0;
  int n_loads    = 0;
  int n_xforms   = 0;
  int n_checked  = 0;
  int n_ovf      = 0;
  int n_errors   = 0;
  logic quiet;

  assign quiet = (n_accepted >= QUIET_LO) && (n_accepted < QUIET_HI);

  vertex_transform_4x4_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .elem_row   (elem_row),
    .elem_col   (elem_col),
    .elem_value (elem_value),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .vec_w      (vec_w),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .overflow   (overflow)
  );

  always #1 clk = ~clk;

  // Updates the matrix on a load, or queues the transformed vertex.
  function automatic void predict_item(vt_item_t it);
    logic signed [IO_BITS-1:0] v [DIM];
    logic signed [IO_BITS-1:0] comp [DIM];
    longint                    acc;
    logic                      ovf;
    vertex_out_t               res;
    if (it.act == ACT_LOAD) begin
      matrix_q[int'(it.row) * DIM + int'(it.col)] = it.value;
      n_loads++;
    end else begin
      v[0] = it.x;
      v[1] = it.y;
      v[2] = it.z;
      v[3] = it.w;
      ovf  = 1'b0;
      for (int c = 0; c < DIM; c++) begin
        acc = 0;
        // each product is exact in 64 bits; >>> floors toward minus infinity
        for (int r = 0; r < DIM; r++)
          acc += (longint'(matrix_q[r*DIM + c]) * longint'(v[r])) >>> FRAC;
        if (acc > WORD_MAX) begin
          acc = WORD_MAX;
          ovf = 1'b1;
        end else if (acc < WORD_MIN) begin
          acc = WORD_MIN;
          ovf = 1'b1;
        end
        comp[c] = IO_BITS'(acc);
      end
      res.x   = comp[0];
      res.y   = comp[1];
      res.z   = comp[2];
      res.w   = comp[3];
      res.ovf = ovf;
      vertex_q.push_back(res);
      n_xforms++;
    end
  endfunction

  function automatic logic signed [IO_BITS-1:0] rand_q();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      return int'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;   // +/- 8.0
    end else if (sel < 80) begin
      return $urandom;
    end else if (sel < 90) begin
      case ($urandom_range(0, 5))
        0:       return Q_MAX;
        1:       return Q_MIN;
        2:       return '0;
        3:       return Q_ONE;
        4:       return Q_NEG_ONE;
        default: return Q_LSB_NEG;
      endcase
    end else begin
      return int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;   // +/- 256.0
    end
  endfunction

  // ignored fields always carry random junk
  function automatic vt_item_t mk_load(int row, int col, logic signed [IO_BITS-1:0] value);
    vt_item_t it;
    it.act   = ACT_LOAD;
    it.row   = IDX_BITS'(row);
    it.col   = IDX_BITS'(col);
    it.value = value;
    it.x     = $urandom;
    it.y     = $urandom;
    it.z     = $urandom;
    it.w     = $urandom;
    return it;
  endfunction

  function automatic vt_item_t mk_xform(logic signed [IO_BITS-1:0] x,
                                        logic signed [IO_BITS-1:0] y,
                                        logic signed [IO_BITS-1:0] z,
                                        logic signed [IO_BITS-1:0] w);
    vt_item_t it;
    it.act   = ACT_XFORM;
    it.row   = IDX_BITS'($urandom_range(0, 3));
    it.col   = IDX_BITS'($urandom_range(0, 3));
    it.value = $urandom;
    it.x     = x;
    it.y     = y;
    it.z     = z;
    it.w     = w;
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [IO_BITS-1:0] got,
                                 logic [IO_BITS-1:0] want);
    n_errors++;
    if (n_errors <= 50)
      $display("[%0t] mismatch on %s, result %0d: got %h expected %h",
               $time, field, n_checked, got, want);
  endtask

  task automatic check_vertex();
    vertex_out_t want;
    if (vertex_q.size() == 0) begin
      report_mismatch("unexpected result", out_x, '0);
    end else begin
      want = vertex_q.pop_front();
      if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
      if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
      if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
      if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
      if (overflow !== want.ovf)
        report_mismatch("overflow", IO_BITS'(overflow), IO_BITS'(want.ovf));
      if (want.ovf) n_ovf++;
    end
    n_checked++;
  endtask

  // driver: predicts on acceptance, then presents the next pending item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_item(cur_item);
        n_accepted++;
      end
      if (stim_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_item = stim_q.pop_front();
        in_valid   <= 1'b1;
        action     <= cur_item.act;
        elem_row   <= cur_item.row;
        elem_col   <= cur_item.col;
        elem_value <= cur_item.value;
        vec_x      <= cur_item.x;
        vec_y      <= cur_item.y;
        vec_z      <= cur_item.z;
        vec_w      <= cur_item.w;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transaction and throttles out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_vertex();
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    #200000;
    $display("timeout: run did not drain");
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < DIM*DIM; i++)
      matrix_q[i] = ((i / DIM) == (i % DIM)) ? Q_ONE : '0;

    // directed: identity, saturation both ways, floor rounding, load-use order
    stim_q.push_back(mk_xform(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN));
    stim_q.push_back(mk_xform('0, '0, '0, '0));
    stim_q.push_back(mk_xform(32'sd1, Q_LSB_NEG, 32'sh1234_5678, 32'shEDCB_A988));
    stim_q.push_back(mk_load(0, 0, Q_MAX));
    stim_q.push_back(mk_xform(Q_MAX, '0, '0, '0));
    stim_q.push_back(mk_xform(Q_MIN, '0, '0, '0));
    stim_q.push_back(mk_load(0, 0, Q_MIN));
    stim_q.push_back(mk_xform(Q_MIN, '0, '0, '0));
    stim_q.push_back(mk_xform(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    stim_q.push_back(mk_load(1, 1, Q_HALF));
    stim_q.push_back(mk_xform('0, Q_LSB_NEG, '0, '0));
    stim_q.push_back(mk_xform('0, 32'sd1, '0, '0));
    stim_q.push_back(mk_load(3, 3, Q_NEG_ONE));
    stim_q.push_back(mk_load(2, 1, Q_MIN));
    stim_q.push_back(mk_load(1, 2, Q_MAX));
    stim_q.push_back(mk_load(3, 0, '0));
    stim_q.push_back(mk_xform(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    stim_q.push_back(mk_xform(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    stim_q.push_back(mk_load(0, 3, Q_ONE));
    stim_q.push_back(mk_load(0, 0, Q_ONE));
    stim_q.push_back(mk_xform(rand_q(), rand_q(), rand_q(), rand_q()));
    stim_q.push_back(mk_load(2, 2, '0));
    stim_q.push_back(mk_xform(Q_NEG_ONE, Q_HALF, Q_LSB_NEG, Q_ONE));

    // random: mixed loads and transforms, with a full small-valued matrix
    // reload now and then so results are not all saturated
    for (int n = 0; n < 400; n++) begin
      if (n % 100 == 0) begin
        for (int e = 0; e < DIM*DIM; e++)
          stim_q.push_back(mk_load(e / DIM, e % DIM,
                                   int'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000));
      end
      if ($urandom_range(0, 99) < 40)
        stim_q.push_back(mk_load($urandom_range(0, 3), $urandom_range(0, 3), rand_q()));
      else
        stim_q.push_back(mk_xform(rand_q(), rand_q(), rand_q(), rand_q()));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    for (int k = 0; k < 5000 && vertex_q.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (vertex_q.size() != 0) begin
      $display("%0d expected results never arrived", vertex_q.size());
      n_errors += vertex_q.size();
    end

    $display("covered %0d element loads and %0d vector transforms", n_loads, n_xforms);
    $display("%0d results checked, %0d saturated, %0d mismatches", n_checked, n_ovf, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/vt44_pkg.sv
rtl/core/vt44_cell.sv
rtl/core/vt44_sat.sv
rtl/core/vertex_transform_4x4_unit.sv
tb/vertex_transform_4x4_unit_tb.sv
